// ===== hw/rtl/qty_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qty_pkg
// Shared types, widths and the CORDIC arctangent table for the
// quaternion-to-yaw pipeline.
// ----------------------------------------------------------------------------
package qty_pkg;

  localparam int QW          = 16;  // quaternion component width
  localparam int PW          = 32;  // position width
  localparam int YW          = 16;  // yaw output width
  localparam int NW          = 30;  // normalized CORDIC input width
  localparam int NORM_MSB    = 29;  // leading one lands here after normalizing
  localparam int CW          = 34;  // CORDIC x/y datapath width
  localparam int ZW          = 32;  // angle accumulator width (deg * 2^22)
  localparam int ATAN_LEN    = 24;
  localparam int YAW_MAX     = 23040;
  localparam int ROUND_SHIFT = 15;

  typedef logic signed [QW-1:0] quat_t;
  typedef logic signed [PW-1:0] pos_t;
  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] ang_t;
  typedef logic signed [YW-1:0] yaw_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
  } side_t;

  typedef struct packed {
    logic t3_neg;
    logic t4_neg;
    logic zero;
  } flags_t;

  localparam ang_t Z_180  = 32'sd754974720;  // 180 degrees
  localparam ang_t Z_HALF = 32'sd16384;      // half of one 1/128 degree step

  // atan(2^-i) in degrees * 2^22
  localparam ang_t ATAN_TAB [ATAN_LEN] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

  // Signed width that holds t3 and t4 for a given fraction count
  function automatic int t_width(input int frac);
    int w;
    w = 2 * frac + 2;
    return (w > 35) ? w : 35;
  endfunction

endpackage

// ===== hw/rtl/quaternion_to_yaw_degrees.sv =====
`timescale 1ns / 1ps
// Converts an orientation quaternion (Q1.15) to yaw in 1/128 degree units,
// range -23040..+23040, and carries the Q16.16 position alongside unchanged.
// Fully pipelined: one sample per cycle while the output is taken; 2
// product/sum stages, 3 normalize stages, one per CORDIC rotation, 2 for
// fold/round. The CORDIC rotation count sets the depth. Every stage holds
// its own valid bit and ready ripples back stage by stage, so bubbles fill
// and a sample is taken while a finished result waits at the output if any stage is empty.
// ----------------------------------------------------------------------------
// quaternion_to_yaw_degrees
// Top level: quaternion terms, normalization, CORDIC arctangent, yaw output.
// ----------------------------------------------------------------------------
module quaternion_to_yaw_degrees #(
  parameter int CORDIC_STAGES  = 16,
  parameter int QUAT_FRAC_BITS = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qty_pkg::quat_t in_quat_x,
  input  qty_pkg::quat_t in_quat_y,
  input  qty_pkg::quat_t in_quat_z,
  input  qty_pkg::quat_t in_quat_w,
  input  qty_pkg::pos_t  in_position_x,
  input  qty_pkg::pos_t  in_position_y,
  output logic           out_valid,
  input  logic           out_ready,
  output qty_pkg::pos_t  out_position_x,
  output qty_pkg::pos_t  out_position_y,
  output qty_pkg::yaw_t  out_yaw_degrees
);
  import qty_pkg::*;

  localparam int TW = t_width(QUAT_FRAC_BITS);

  side_t                in_side, terms_side, norm_side, cordic_side, yaw_side;
  logic                 terms_valid, terms_ready;
  logic signed [TW-1:0] t3, t4;
  logic                 norm_valid, norm_ready;
  logic [NW-1:0]        norm_x, norm_y;
  flags_t               norm_flags, cordic_flags;
  logic                 cordic_valid, cordic_ready;
  ang_t                 cordic_z;

  assign in_side.x = in_position_x;
  assign in_side.y = in_position_y;

  qty_terms #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .TW             (TW)
  ) u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_qx     (in_quat_x),
    .in_qy     (in_quat_y),
    .in_qz     (in_quat_z),
    .in_qw     (in_quat_w),
    .in_side   (in_side),
    .out_valid (terms_valid),
    .out_ready (terms_ready),
    .out_t3    (t3),
    .out_t4    (t4),
    .out_side  (terms_side)
  );

  qty_norm #(
    .TW (TW)
  ) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (terms_valid),
    .in_ready  (terms_ready),
    .in_t3     (t3),
    .in_t4     (t4),
    .in_side   (terms_side),
    .out_valid (norm_valid),
    .out_ready (norm_ready),
    .out_x     (norm_x),
    .out_y     (norm_y),
    .out_flags (norm_flags),
    .out_side  (norm_side)
  );

  qty_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (norm_valid),
    .in_ready  (norm_ready),
    .in_x      (norm_x),
    .in_y      (norm_y),
    .in_flags  (norm_flags),
    .in_side   (norm_side),
    .out_valid (cordic_valid),
    .out_ready (cordic_ready),
    .out_z     (cordic_z),
    .out_flags (cordic_flags),
    .out_side  (cordic_side)
  );

  qty_yaw u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cordic_valid),
    .in_ready  (cordic_ready),
    .in_z      (cordic_z),
    .in_flags  (cordic_flags),
    .in_side   (cordic_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_yaw   (out_yaw_degrees),
    .out_side  (yaw_side)
  );

  assign out_position_x = yaw_side.x;
  assign out_position_y = yaw_side.y;

  // pipeline comes up empty after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with the output draining, every stage can advance
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_degrees <= 16'sd23040) && (out_yaw_degrees >= -16'sd23040))
    else $error("yaw out of range");

endmodule

// ===== hw/rtl/qty_terms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qty_terms
// Two stages: the four quaternion products, then t3 = 2(wz+xy) and
// t4 = 1 - 2(y^2+z^2) at full width.
// ----------------------------------------------------------------------------
module qty_terms #(
  parameter int QUAT_FRAC_BITS = 15,
  parameter int TW             = 35
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qty_pkg::quat_t       in_qx,
  input  qty_pkg::quat_t       in_qy,
  input  qty_pkg::quat_t       in_qz,
  input  qty_pkg::quat_t       in_qw,
  input  qty_pkg::side_t       in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [TW-1:0] out_t3,
  output logic signed [TW-1:0] out_t4,
  output qty_pkg::side_t       out_side
);
  import qty_pkg::*;

  localparam int MUL_W = 2 * QW;
  localparam logic signed [TW-1:0] ONE = {{(TW-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);

  logic                    p_v_r;
  logic                    p_ready;
  logic signed [MUL_W-1:0] p_wz_r, p_xy_r, p_yy_r, p_zz_r;
  side_t                   p_side_r;

  logic                    t_v_r;
  logic                    t_ready;
  logic signed [TW-1:0]    t3_r, t4_r, t3_nxt, t4_nxt;
  side_t                   t_side_r;
  logic signed [MUL_W:0]   sum_a, sum_b;

  assign t_ready  = !t_v_r || out_ready;
  assign p_ready  = !p_v_r || t_ready;
  assign in_ready = p_ready;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_ready) begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && in_valid) begin
      p_wz_r   <= in_qw * in_qz;
      p_xy_r   <= in_qx * in_qy;
      p_yy_r   <= in_qy * in_qy;
      p_zz_r   <= in_qz * in_qz;
      p_side_r <= in_side;
    end
  end

  // stage 2: sums, doubled by a left shift
  always_comb begin
    sum_a  = {p_wz_r[MUL_W-1], p_wz_r} + {p_xy_r[MUL_W-1], p_xy_r};
    sum_b  = {p_yy_r[MUL_W-1], p_yy_r} + {p_zz_r[MUL_W-1], p_zz_r};
    t3_nxt = {{(TW-MUL_W-2){sum_a[MUL_W]}}, sum_a, 1'b0};
    t4_nxt = ONE - {{(TW-MUL_W-2){1'b0}}, sum_b, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (t_ready) begin
      t_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (t_ready && p_v_r) begin
      t3_r     <= t3_nxt;
      t4_r     <= t4_nxt;
      t_side_r <= p_side_r;
    end
  end

  assign out_valid = t_v_r;
  assign out_t3    = t3_r;
  assign out_t4    = t4_r;
  assign out_side  = t_side_r;

endmodule

// ===== hw/rtl/qty_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qty_norm
// Three stages: magnitudes and sign flags, leading-one search, then a common
// shift that puts the larger magnitude in [2^29, 2^30).
// ----------------------------------------------------------------------------
module qty_norm #(
  parameter int TW = 35
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [TW-1:0]   in_t3,
  input  logic signed [TW-1:0]   in_t4,
  input  qty_pkg::side_t         in_side,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [qty_pkg::NW-1:0] out_x,
  output logic [qty_pkg::NW-1:0] out_y,
  output qty_pkg::flags_t        out_flags,
  output qty_pkg::side_t         out_side
);
  import qty_pkg::*;

  localparam int MW = TW - 1;
  localparam int LW = $clog2(MW);
  localparam logic [LW-1:0] TARGET = LW'(NORM_MSB);

  // stage A
  logic          a_v_r, a_ready;
  logic [MW-1:0] ax_r, ay_r, ax_nxt, ay_nxt;
  flags_t        a_flags_r, a_flags_nxt;
  side_t         a_side_r;

  // stage B
  logic          b_v_r, b_ready;
  logic [MW-1:0] bx_r, by_r, b_or;
  logic [LW-1:0] lead_r, lead_nxt;
  flags_t        b_flags_r;
  side_t         b_side_r;

  // stage C
  logic          c_v_r, c_ready;
  logic [NW-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  flags_t        c_flags_r;
  side_t         c_side_r;

  assign c_ready  = !c_v_r || out_ready;
  assign b_ready  = !b_v_r || c_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    ax_nxt             = in_t4[TW-1] ? MW'(-in_t4) : MW'(in_t4);
    ay_nxt             = in_t3[TW-1] ? MW'(-in_t3) : MW'(in_t3);
    a_flags_nxt.t3_neg = in_t3[TW-1];
    a_flags_nxt.t4_neg = in_t4[TW-1];
    a_flags_nxt.zero   = (in_t3 == '0) && (in_t4 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      ax_r      <= ax_nxt;
      ay_r      <= ay_nxt;
      a_flags_r <= a_flags_nxt;
      a_side_r  <= in_side;
    end
  end

  // the top bit of (ax | ay) is the top bit of the larger one
  assign b_or = ax_r | ay_r;

  always_comb begin
    lead_nxt = '0;
    for (int k = 0; k < MW; k++) begin
      if (b_or[k]) lead_nxt = LW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_v_r) begin
      bx_r      <= ax_r;
      by_r      <= ay_r;
      lead_r    <= lead_nxt;
      b_flags_r <= a_flags_r;
      b_side_r  <= a_side_r;
    end
  end

  // right shifts truncate, left shifts are exact
  always_comb begin
    if (lead_r >= TARGET) begin
      cx_nxt = NW'(bx_r >> (lead_r - TARGET));
      cy_nxt = NW'(by_r >> (lead_r - TARGET));
    end else begin
      cx_nxt = bx_r[NW-1:0] << (TARGET - lead_r);
      cy_nxt = by_r[NW-1:0] << (TARGET - lead_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_ready) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_v_r) begin
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      c_flags_r <= b_flags_r;
      c_side_r  <= b_side_r;
    end
  end

  assign out_valid = c_v_r;
  assign out_x     = cx_r;
  assign out_y     = cy_r;
  assign out_flags = c_flags_r;
  assign out_side  = c_side_r;

endmodule

// ===== hw/rtl/qty_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qty_cordic
// Unrolled vectoring CORDIC, one register stage per rotation. Drives y to
// zero and accumulates the angle in degrees * 2^22.
// ----------------------------------------------------------------------------
module qty_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [qty_pkg::NW-1:0] in_x,
  input  logic [qty_pkg::NW-1:0] in_y,
  input  qty_pkg::flags_t        in_flags,
  input  qty_pkg::side_t         in_side,
  output logic                   out_valid,
  input  logic                   out_ready,
  output qty_pkg::ang_t          out_z,
  output qty_pkg::flags_t        out_flags,
  output qty_pkg::side_t         out_side
);
  import qty_pkg::*;

  localparam int NST = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  logic   v_r     [NST];
  cval_t  x_r     [NST];
  cval_t  y_r     [NST];
  ang_t   z_r     [NST];
  flags_t flags_r [NST];
  side_t  side_r  [NST];
  logic   rdy     [NST+1];

  assign rdy[NST]  = out_ready;
  assign in_ready  = rdy[0];

  for (genvar i = 0; i < NST; i++) begin : g_stage
    cval_t  xi, yi, dx, dy, x_nxt, y_nxt;
    ang_t   zi, z_nxt;
    flags_t fi;
    side_t  si;
    logic   vi;

    if (i == 0) begin : g_first
      assign xi = {{(CW-NW){1'b0}}, in_x};
      assign yi = {{(CW-NW){1'b0}}, in_y};
      assign zi = '0;
      assign fi = in_flags;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = flags_r[i-1];
      assign si = side_r[i-1];
      assign vi = v_r[i-1];
    end

    assign rdy[i] = !v_r[i] || rdy[i+1];
    assign dx     = yi >>> i;
    assign dy     = xi >>> i;

    always_comb begin
      if (!yi[CW-1]) begin
        x_nxt = xi + dx;
        y_nxt = yi - dy;
        z_nxt = zi + ATAN_TAB[i];
      end else begin
        x_nxt = xi - dx;
        y_nxt = yi + dy;
        z_nxt = zi - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vi) begin
        x_r[i]     <= x_nxt;
        y_r[i]     <= y_nxt;
        z_r[i]     <= z_nxt;
        flags_r[i] <= fi;
        side_r[i]  <= si;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_z     = z_r[NST-1];
  assign out_flags = flags_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

// ===== hw/rtl/qty_yaw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qty_yaw
// Two stages: quadrant fold and clamp, then rounding to 1/128 degree,
// saturation and sign. The second stage is the block's output register.
// ----------------------------------------------------------------------------
module qty_yaw (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  qty_pkg::ang_t   in_z,
  input  qty_pkg::flags_t in_flags,
  input  qty_pkg::side_t  in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output qty_pkg::yaw_t   out_yaw,
  output qty_pkg::side_t  out_side
);
  import qty_pkg::*;

  logic          m_v_r, m_ready;
  ang_t          m_r, m_raw, m_nxt;
  flags_t        m_flags_r;
  side_t         m_side_r;

  logic          o_v_r, o_ready;
  yaw_t          yaw_r, yaw_nxt;
  side_t         o_side_r;
  ang_t          rnd;
  logic [YW-1:0] mag;

  assign o_ready  = !o_v_r || out_ready;
  assign m_ready  = !m_v_r || o_ready;
  assign in_ready = m_ready;

  always_comb begin
    m_raw = in_flags.t4_neg ? (Z_180 - in_z) : in_z;
    if (m_raw < 0) begin
      m_nxt = '0;
    end else if (m_raw > Z_180) begin
      m_nxt = Z_180;
    end else begin
      m_nxt = m_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_ready) begin
      m_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      m_r       <= m_nxt;
      m_flags_r <= in_flags;
      m_side_r  <= in_side;
    end
  end

  // m is non-negative here, so the arithmetic shift rounds half away from zero
  always_comb begin
    rnd = (m_r + Z_HALF) >>> ROUND_SHIFT;
    if (rnd > ang_t'(YAW_MAX)) begin
      mag = YW'(YAW_MAX);
    end else begin
      mag = rnd[YW-1:0];
    end
    if (m_flags_r.zero) begin
      yaw_nxt = '0;
    end else if (m_flags_r.t3_neg) begin
      yaw_nxt = -mag;
    end else begin
      yaw_nxt = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_ready) begin
      o_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && m_v_r) begin
      yaw_r    <= yaw_nxt;
      o_side_r <= m_side_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_yaw   = yaw_r;
  assign out_side  = o_side_r;

endmodule
